@@ rtl/hfvl_pkg.sv @@
// ---------------------------------------------------------------------------
// hfvl_pkg
// Shared types, constants and helpers for the header field value locator.
// ---------------------------------------------------------------------------
package hfvl_pkg;

  // block size limit and the position where the counter stops
  localparam int unsigned MAX_BLOCK_BYTES = 65536;
  localparam logic [15:0] POS_LIMIT =
    ((MAX_BLOCK_BYTES - 1) < 65535) ? 16'(MAX_BLOCK_BYTES - 1) : 16'hFFFF;

  // longest header name
  localparam logic [4:0] NAME_MAX_BYTES = 5'd16;

  // character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_NAME_LOW  = 2'd0,
    REG_NAME_HIGH = 2'd1,
    REG_NAME_LEN  = 2'd2
  } reg_idx_t;

  // parser modes
  typedef enum logic [2:0] {
    M_SKIP        = 3'd0,
    M_MATCH       = 3'd1,
    M_AFTER_NAME  = 3'd2,
    M_LEAD_BLANKS = 3'd3,
    M_POST_SEP    = 3'd4,
    M_VALUE       = 3'd5,
    M_DONE        = 3'd6
  } mode_t;

  // configuration seen by the parser
  typedef struct packed {
    logic [63:0] name_low;
    logic [63:0] name_high;
    logic [4:0]  name_len;
  } cfg_t;

  // classified byte as held in the queue
  typedef struct packed {
    logic [7:0] folded;
    logic       is_zero;
    logic       is_lf;
    logic       is_crlf;
    logic       is_blank;
    logic       is_sep;
    logic       is_vchar;
    logic       last;
  } cls_t;

  // upper-case ascii letters, leave everything else
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      r = c - CASE_GAP;
    end
    return r;
  endfunction

  // pick one name character out of the two name words
  function automatic logic [7:0] name_char(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [3:0] idx);
    logic [127:0] both;
    both = {hi, lo};
    return both[{idx, 3'b000} +: 8];
  endfunction

endpackage

@@ rtl/hfvl_if.sv @@
// ---------------------------------------------------------------------------
// hfvl_in_if / hfvl_out_if
// Valid/ready channels for header bytes and for located results.
// ---------------------------------------------------------------------------
interface hfvl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_end;

  modport source (output valid, output data_byte, output block_end, input ready);
  modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

interface hfvl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] value_offset;
  logic [15:0] value_length;
  logic        overflow;

  modport source (output valid, output found, output value_offset, output value_length,
                  output overflow, input ready);
  modport sink   (input valid, input found, input value_offset, input value_length,
                  input overflow, output ready);
endinterface

@@ rtl/hfvl_front.sv @@
// ---------------------------------------------------------------------------
// hfvl_front
// Classifies each incoming header byte for the parser.
// ---------------------------------------------------------------------------
module hfvl_front (
  input  logic          [7:0] data_byte,
  input  logic                block_end,
  output hfvl_pkg::cls_t      cls
);
  import hfvl_pkg::*;

  // byte classes
  always_comb begin
    cls.folded   = fold_case(data_byte);
    cls.is_zero  = (data_byte == 8'h00);
    cls.is_lf    = (data_byte == CH_LF);
    cls.is_crlf  = (data_byte == CH_LF) || (data_byte == CH_CR);
    cls.is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
    cls.is_sep   = (data_byte == CH_COLON) || (data_byte == CH_EQUAL);
    cls.is_vchar = (data_byte > CH_SPACE) && (data_byte != CH_DEL);
    cls.last     = block_end;
  end

endmodule

@@ rtl/hfvl_queue.sv @@
// ---------------------------------------------------------------------------
// hfvl_queue
// Short queue of classified bytes between front and parser.
// ---------------------------------------------------------------------------
module hfvl_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hfvl_pkg::cls_t push_word,
  output logic           full,
  output logic           head_valid,
  output hfvl_pkg::cls_t head_word,
  input  logic           pop
);
  import hfvl_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  cls_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head_word  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/hfvl_back.sv @@
// ---------------------------------------------------------------------------
// hfvl_back
// Header line parser: name match, separator, value bounds, result register.
// ---------------------------------------------------------------------------
module hfvl_back (
  input  logic             clk,
  input  logic             rst,
  input  hfvl_pkg::cfg_t   cfg,
  input  logic             head_valid,
  input  hfvl_pkg::cls_t   head_word,
  output logic             pop,
  hfvl_out_if.source       res
);
  import hfvl_pkg::*;

  mode_t       mode, mode_next;
  logic [4:0]  name_idx, name_idx_next;
  logic [15:0] pos, pos_next;
  logic [15:0] vstart, vstart_next;
  logic [15:0] trim_end, trim_end_next;
  logic        sat, sat_next;

  logic        take;
  logic        emit;
  logic        emit_found;
  logic [4:0]  len_eff;
  logic        name_hit;
  logic [15:0] pos_plus;
  mode_t       skip_mode;
  mode_t       after_mode;
  logic        at_limit;

  assign take = head_valid && (!res.valid || res.ready);
  assign pop  = take;

  assign len_eff  = (cfg.name_len > NAME_MAX_BYTES) ? NAME_MAX_BYTES : cfg.name_len;
  assign name_hit = (head_word.folded ==
                     fold_case(name_char(cfg.name_low, cfg.name_high, name_idx[3:0])));
  assign pos_plus = (pos == 16'hFFFF) ? 16'hFFFF : pos + 16'd1;
  assign at_limit = (pos >= POS_LIMIT);

  // where a rejected line goes, and what follows a matched name
  assign skip_mode  = head_word.is_lf ? M_MATCH : M_SKIP;
  assign after_mode = head_word.is_blank ? M_LEAD_BLANKS :
                      head_word.is_sep   ? M_POST_SEP : skip_mode;

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_SKIP;
      name_idx <= '0;
      pos      <= '0;
      vstart   <= '0;
      trim_end <= '0;
      sat      <= 1'b0;
    end else if (take) begin
      mode     <= mode_next;
      name_idx <= name_idx_next;
      pos      <= pos_next;
      vstart   <= vstart_next;
      trim_end <= trim_end_next;
      sat      <= sat_next;
    end
  end

  // next state for one byte
  always_comb begin
    mode_next     = mode;
    name_idx_next = name_idx;
    vstart_next   = vstart;
    trim_end_next = trim_end;
    emit          = 1'b0;
    emit_found    = 1'b0;

    if (mode != M_DONE && head_word.is_zero) begin
      emit      = 1'b1;
      mode_next = M_DONE;
    end else begin
      unique case (mode)
        M_SKIP: begin
          if (head_word.is_lf) begin
            mode_next     = M_MATCH;
            name_idx_next = '0;
          end
        end
        M_MATCH: begin
          if (name_idx >= len_eff) begin
            mode_next     = after_mode;
            name_idx_next = '0;
          end else if (name_hit) begin
            name_idx_next = name_idx + 5'd1;
            if ((name_idx + 5'd1) >= len_eff) begin
              mode_next = M_AFTER_NAME;
            end
          end else begin
            mode_next     = skip_mode;
            name_idx_next = '0;
          end
        end
        M_AFTER_NAME: begin
          mode_next     = after_mode;
          name_idx_next = '0;
        end
        M_LEAD_BLANKS, M_POST_SEP: begin
          if (head_word.is_blank) begin
            mode_next = mode;
          end else if (head_word.is_sep && mode == M_LEAD_BLANKS) begin
            mode_next = M_POST_SEP;
          end else begin
            // first value byte: an empty value rejects the line
            vstart_next   = pos;
            trim_end_next = pos;
            name_idx_next = '0;
            if (head_word.is_vchar) begin
              trim_end_next = pos_plus;
              mode_next     = M_VALUE;
            end else if (head_word.is_crlf) begin
              mode_next = skip_mode;
            end else begin
              mode_next = M_SKIP;
            end
          end
        end
        M_VALUE: begin
          name_idx_next = '0;
          if (head_word.is_blank) begin
            mode_next = M_VALUE;
          end else if (head_word.is_vchar) begin
            trim_end_next = pos_plus;
          end else if (head_word.is_crlf) begin
            if (trim_end == vstart) begin
              mode_next = skip_mode;
            end else begin
              emit       = 1'b1;
              emit_found = 1'b1;
              mode_next  = M_DONE;
            end
          end else begin
            mode_next = M_SKIP;
          end
        end
        M_DONE: begin
          mode_next = M_DONE;
        end
        default: begin
          mode_next = M_SKIP;
        end
      endcase
    end

    // block end: not-found result if nothing went out yet
    if (head_word.last && mode != M_DONE && !emit) begin
      emit = 1'b1;
    end

    // position counter stops at its limit
    pos_next = at_limit ? pos : pos + 16'd1;
    sat_next = sat || at_limit;

    if (head_word.last) begin
      mode_next     = M_SKIP;
      name_idx_next = '0;
      pos_next      = '0;
      vstart_next   = '0;
      trim_end_next = '0;
      sat_next      = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take && emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res.found        <= emit_found;
      res.value_offset <= emit_found ? vstart : '0;
      res.value_length <= emit_found ? (trim_end - vstart) : '0;
      res.overflow     <= sat;
    end
  end

  // block end puts the parser back to its start
  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (take && head_word.last) |=> (mode == M_SKIP && pos == '0 && !sat))
    else $error("parser state not cleared after block end");

  // a located value is never empty
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.found) |-> (res.value_length != '0))
    else $error("found result with empty value");

  // not-found results carry no position
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.found) |-> (res.value_offset == '0 && res.value_length == '0))
    else $error("not-found result with nonzero offset or length");

  // counter never runs past its limit
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_LIMIT)
    else $error("position counter beyond limit");

  // trimmed end never falls before the value start
  a_trim_order: assert property (@(posedge clk) disable iff (rst)
    (mode == M_VALUE) |-> (trim_end >= vstart))
    else $error("value end before value start");

endmodule

@@ rtl/header_field_value_locator_unit.sv @@
// ---------------------------------------------------------------------------
// header_field_value_locator_unit
// Finds the value of a configured header name in a byte-wide header block.
// ---------------------------------------------------------------------------
//  channel  dir  word                                              handshake
//  hdr      in   data_byte, block_end                              valid/ready
//  res      out  found, value_offset, value_length, overflow       valid/ready
//  cfg      in   cfg_index, cfg_data                               cfg_we only
//
//  one byte per cycle sustained while res is not stalled; the parser
//  loop settles each byte combinationally; a result goes from the queue slot
//  into the result register; rst (synchronous) clears the queue, the parser
//  and res.valid and resets the name registers; a stalled res holds the parser;
//  hdr keeps taking bytes until the QUEUE_DEPTH entry queue fills
// ---------------------------------------------------------------------------
module header_field_value_locator_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  hfvl_in_if.sink     hdr,
  hfvl_out_if.source  res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import hfvl_pkg::*;

  cfg_t cfg;
  cls_t cls;
  cls_t head_word;
  logic q_full;
  logic head_valid;
  logic pop;

  // name registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.name_low  <= '0;
      cfg.name_high <= '0;
      cfg.name_len  <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NAME_LOW:  cfg.name_low  <= cfg_data;
        REG_NAME_HIGH: cfg.name_high <= cfg_data;
        REG_NAME_LEN:  cfg.name_len  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // classify incoming bytes
  hfvl_front u_front (
    .data_byte (hdr.data_byte),
    .block_end (hdr.block_end),
    .cls       (cls)
  );

  assign hdr.ready = !q_full;

  // queue between front and parser
  hfvl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (hdr.valid),
    .push_word  (cls),
    .full       (q_full),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop)
  );

  // parser and result register
  hfvl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .res        (res)
  );

endmodule

@@ dv/hfvl_value_check.sv @@
// ---------------------------------------------------------------------------
// hfvl_value_check
// Watches the header byte channel, the result channel and the register
// port of the header field value locator. Keeps its own copy of the name
// registers and of the line parser, works out the located value for every
// byte taken, and compares each result word with the oldest one due.
// ---------------------------------------------------------------------------
module hfvl_value_check (
  input  logic        clk,
  input  logic        rst,
  hfvl_in_if          hdr,
  hfvl_out_if         res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          outstanding,
  output int          hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import hfvl_pkg::*;

  // one located value as it leaves the block
  typedef struct packed {
    logic        found;
    logic [15:0] offset;
    logic [15:0] length;
    logic        overflow;
  } located_t;

  located_t due_values[$];

  // name registers
  logic [63:0] nm_lo;
  logic [63:0] nm_hi;
  logic [4:0]  nm_len;

  // parser state
  mode_t       line_mode;
  logic [4:0]  name_idx;
  logic [15:0] byte_pos;
  logic [15:0] vstart;
  logic [15:0] vtrim;
  logic        value_given;
  logic        pos_sat;

  int          seen;

  function automatic logic [7:0] upper(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] name_byte(input logic [3:0] i);
    logic [127:0] both;
    both = {nm_hi, nm_lo};
    return both[i * 8 +: 8];
  endfunction

  task automatic clear_block();
    line_mode   = M_SKIP;
    name_idx    = '0;
    byte_pos    = '0;
    vstart      = '0;
    vtrim       = '0;
    value_given = 1'b0;
    pos_sat     = 1'b0;
  endtask

  task automatic give(input logic f, input logic [15:0] off, input logic [15:0] len,
                      input logic ovf);
    located_t v;
    v.found     = f;
    v.offset    = off;
    v.length    = len;
    v.overflow  = ovf;
    due_values.push_back(v);
    value_given = 1'b1;
    line_mode   = M_DONE;
  endtask

  // advance the parser by one header byte
  task automatic follow_byte(input logic [7:0] b, input logic last);
    logic [15:0] pos;
    logic        ovf;
    logic [4:0]  nlen;
    logic [15:0] vlen;
    bit          again;
    pos  = byte_pos;
    ovf  = pos_sat;
    nlen = (nm_len > NAME_MAX_BYTES) ? NAME_MAX_BYTES : nm_len;
    if (line_mode != M_DONE && !value_given) begin
      if (b == 8'h00) begin
        // zero byte ends the search
        give(1'b0, 16'd0, 16'd0, ovf);
      end else begin
        again = 1'b1;
        while (again) begin
          again = 1'b0;
          case (line_mode)
            M_SKIP: begin
              if (b == CH_LF) begin
                line_mode = M_MATCH;
                name_idx  = '0;
              end
            end
            M_MATCH: begin
              if (name_idx >= nlen) begin
                line_mode = M_AFTER_NAME;
                again     = 1'b1;
              end else if (upper(b) == upper(name_byte(name_idx[3:0]))) begin
                name_idx = name_idx + 5'd1;
                if (name_idx >= nlen) begin
                  line_mode = M_AFTER_NAME;
                end
              end else begin
                line_mode = M_SKIP;
                again     = 1'b1;
              end
            end
            M_AFTER_NAME, M_LEAD_BLANKS, M_POST_SEP: begin
              if (b == CH_SPACE || b == CH_TAB) begin
                if (line_mode == M_AFTER_NAME) begin
                  line_mode = M_LEAD_BLANKS;
                end
              end else if ((b == CH_COLON || b == CH_EQUAL) && line_mode != M_POST_SEP) begin
                line_mode = M_POST_SEP;
              end else if (line_mode == M_AFTER_NAME) begin
                // name was only a prefix
                line_mode = M_SKIP;
                again     = 1'b1;
              end else begin
                vstart    = pos;
                vtrim     = pos;
                line_mode = M_VALUE;
                again     = 1'b1;
              end
            end
            M_VALUE: begin
              if (b > CH_SPACE && b != CH_DEL) begin
                vtrim = (pos == 16'hFFFF) ? 16'hFFFF : pos + 16'd1;
              end else if (b == CH_CR || b == CH_LF) begin
                vlen = vtrim - vstart;
                if (vlen == 16'd0) begin
                  line_mode = M_SKIP;
                  again     = 1'b1;
                end else begin
                  give(1'b1, vstart, vlen, ovf);
                end
              end else if (b != CH_SPACE && b != CH_TAB) begin
                // control byte or del rejects the line
                line_mode = M_SKIP;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
    // position counter stops at its limit
    if (pos >= POS_LIMIT) begin
      pos_sat = 1'b1;
    end else begin
      byte_pos = pos + 16'd1;
    end
    if (last) begin
      if (!value_given) begin
        give(1'b0, 16'd0, 16'd0, ovf);
      end
      clear_block();
    end
  endtask

  // compare one result word with the oldest one due
  task automatic check_word();
    located_t want;
    located_t got;
    got.found    = res.found;
    got.offset   = res.value_offset;
    got.length   = res.value_length;
    got.overflow = res.overflow;
    seen++;
    if (due_values.size() == 0) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: result word %0d with none due: found=%0d off=%0d len=%0d ovf=%0d",
                 $time, seen, got.found, got.offset, got.length, got.overflow);
      end
    end else begin
      want = due_values.pop_front();
      if (want.found == 1'b1) begin
        hits++;
      end
      if (got.found !== want.found || got.offset !== want.offset ||
          got.length !== want.length || got.overflow !== want.overflow) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: result word %0d expected found=%0d off=%0d len=%0d ovf=%0d",
                   $time, seen, want.found, want.offset, want.length, want.overflow);
          $display("%0t: result word %0d actual   found=%0d off=%0d len=%0d ovf=%0d",
                   $time, seen, got.found, got.offset, got.length, got.overflow);
        end
      end
    end
  endtask

  // sample everything at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      nm_lo  = '0;
      nm_hi  = '0;
      nm_len = 5'd1;
      clear_block();
      due_values.delete();
      errors = 0;
      hits   = 0;
      seen   = 0;
    end else begin
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        check_word();
      end
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_NAME_LOW:  nm_lo = cfg_data;
          REG_NAME_HIGH: nm_hi = cfg_data;
          REG_NAME_LEN:  nm_len = cfg_data[4:0];
          default: begin
          end
        endcase
      end
      if (hdr.valid === 1'b1 && hdr.ready === 1'b1) begin
        follow_byte(hdr.data_byte, hdr.block_end);
      end
    end
    outstanding = due_values.size();
  end

endmodule

@@ dv/tb_header_field_value_locator_unit.sv @@
// ---------------------------------------------------------------------------
// tb_header_field_value_locator_unit
// Streams header blocks into the locator under several name settings and
// idle patterns: a few hand-made blocks and random blocks built mostly from
// well-formed header lines. Results are predicted and compared by
// hfvl_value_check.
// ---------------------------------------------------------------------------
module tb_header_field_value_locator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hfvl_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  int          err_cnt;
  int          pend_cnt;
  int          found_cnt;

  hfvl_in_if  hdr_ch ();
  hfvl_out_if res_ch ();

  header_field_value_locator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .hdr       (hdr_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hfvl_value_check chk (
    .clk         (clk),
    .rst         (rst),
    .hdr         (hdr_ch),
    .res         (res_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (err_cnt),
    .outstanding (pend_cnt),
    .hits        (found_cnt)
  );

  localparam logic [63:0] HOST_LO = 64'h0000_0000_7473_6F48;

  // stimulus side copy of the name, only used to build lines
  logic [63:0] cur_lo;
  logic [63:0] cur_hi;
  logic [4:0]  cur_len;

  int          src_pct;
  int          dst_pct;
  int          sent_bytes;
  int          sent_blocks;
  int          name_sets;
  logic [7:0]  blk[$];

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side back-pressure
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= dst_pct);
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("header_field_value_locator_unit: mismatch");
    $finish;
  end

  // one header word, with optional idle cycles before it
  task automatic put_byte(input logic [7:0] b, input logic last);
    while (src_pct != 0 && $urandom_range(99) < src_pct) begin
      hdr_ch.valid <= 1'b0;
      @(negedge clk);
    end
    hdr_ch.valid     <= 1'b1;
    hdr_ch.data_byte <= b;
    hdr_ch.block_end <= last;
    do begin
      @(posedge clk);
    end while (hdr_ch.ready !== 1'b1);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_queue(input bit close);
    for (int i = 0; i < blk.size(); i++) begin
      put_byte(blk[i], close && (i == blk.size() - 1));
    end
    if (close) begin
      sent_blocks++;
    end
    blk.delete();
  endtask

  // stop sending and let the block run dry
  task automatic settle();
    hdr_ch.valid <= 1'b0;
    while (pend_cnt != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
  endtask

  task automatic load_name(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [63:0] len_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NAME_LOW;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= REG_NAME_HIGH;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_index <= REG_NAME_LEN;
    cfg_data  <= len_word;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_lo  = lo;
    cur_hi  = hi;
    cur_len = len_word[4:0];
    name_sets++;
  endtask

  // random name setting; a negative length picks one at random
  task automatic pick_name(input int want_len, input bit all_ones);
    logic [127:0] both;
    logic [7:0]   c;
    logic [63:0]  lw;
    int           r;
    int           n;
    r = $urandom_range(99);
    if (want_len >= 0) begin
      n = want_len;
    end else if (r < 65) begin
      n = $urandom_range(1, 16);
    end else if (r < 82) begin
      n = $urandom_range(1, 3);
    end else if (r < 91) begin
      n = 0;
    end else begin
      n = $urandom_range(17, 31);
    end
    for (int i = 0; i < 16; i++) begin
      r = $urandom_range(99);
      if (r < 75) begin
        c = 8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(1) ? 8'h20 : 8'h00);
      end else if (r < 85) begin
        c = $urandom_range(1) ? 8'h2D : 8'($urandom_range(8'h30, 8'h39));
      end else if (r < 97) begin
        c = 8'($urandom_range(1, 255));
      end else begin
        c = 8'h00;
      end
      both[i * 8 +: 8] = c;
    end
    if (all_ones) begin
      both = '1;
    end
    // upper bits of the length word carry noise
    lw = {$urandom, $urandom};
    lw[4:0] = 5'(n);
    load_name(both[63:0], both[127:64], lw);
  endtask

  function automatic logic [7:0] name_at(input int i);
    logic [127:0] both;
    both = {cur_hi, cur_lo};
    return both[i * 8 +: 8];
  endfunction

  function automatic int name_span();
    return (cur_len > 5'd16) ? 16 : int'(cur_len);
  endfunction

  function automatic logic [7:0] value_char();
    if ($urandom_range(99) < 80) begin
      return 8'($urandom_range(8'h21, 8'h7E));
    end
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      blk.push_back(8'(s[i]));
    end
  endtask

  task automatic add_eol();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      blk.push_back(CH_CR);
      blk.push_back(CH_LF);
    end else if (r < 90) begin
      blk.push_back(CH_LF);
    end else begin
      blk.push_back(CH_CR);
    end
  endtask

  // name with letter case flipped at random, the first k characters
  task automatic add_name(input int k);
    logic [7:0] c;
    for (int i = 0; i < k; i++) begin
      c = name_at(i);
      if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
        if ($urandom_range(1)) begin
          c = c ^ CASE_GAP;
        end
      end
      blk.push_back(c);
    end
  endtask

  // blanks and/or separator between name and value
  task automatic add_sep();
    int lead;
    lead = $urandom_range(0, 2);
    for (int i = 0; i < lead; i++) begin
      blk.push_back(blank_char());
    end
    if (lead == 0 || $urandom_range(1)) begin
      blk.push_back($urandom_range(1) ? CH_COLON : CH_EQUAL);
      repeat ($urandom_range(0, 2)) blk.push_back(blank_char());
    end
  endtask

  task automatic add_value();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      blk.push_back(value_char());
      if (i < n - 1 && $urandom_range(99) < 15) begin
        blk.push_back(blank_char());
      end
    end
    repeat ($urandom_range(0, 2)) blk.push_back(blank_char());
  endtask

  // one header line of a random kind
  task automatic add_line();
    int r;
    int k;
    r = $urandom_range(99);
    k = name_span();
    if (r < 40) begin
      // well-formed line with the searched name
      add_name(k);
      add_sep();
      add_value();
      add_eol();
    end else if (r < 48) begin
      // name cut short
      add_name((k > 0) ? $urandom_range(0, k - 1) : 0);
      blk.push_back(CH_COLON);
      add_value();
      add_eol();
    end else if (r < 55) begin
      // name followed by one more character
      add_name(k);
      blk.push_back(8'($urandom_range(8'h41, 8'h5A)));
      add_sep();
      add_value();
      add_eol();
    end else if (r < 64) begin
      // control byte or del inside the value
      add_name(k);
      add_sep();
      blk.push_back(value_char());
      blk.push_back($urandom_range(3) == 0 ? CH_DEL : 8'($urandom_range(1, 31)));
      add_value();
      add_eol();
    end else if (r < 73) begin
      // empty value
      add_name(k);
      add_sep();
      repeat ($urandom_range(0, 2)) blk.push_back(blank_char());
      add_eol();
    end else if (r < 87) begin
      // some other header
      repeat ($urandom_range(1, 5)) blk.push_back(8'($urandom_range(8'h61, 8'h7A)));
      blk.push_back(CH_COLON);
      blk.push_back(CH_SPACE);
      add_value();
      add_eol();
    end else if (r < 95) begin
      // raw noise
      repeat ($urandom_range(1, 8)) blk.push_back(8'($urandom_range(1, 255)));
      blk.push_back(CH_LF);
    end else begin
      // zero byte, the rest is ignored
      blk.push_back(8'h00);
      repeat ($urandom_range(0, 3)) blk.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_block();
    int cut;
    repeat ($urandom_range(0, 5)) blk.push_back(8'($urandom_range(8'h41, 8'h5A)));
    if ($urandom_range(99) < 90) begin
      blk.push_back(CH_LF);
    end else begin
      add_eol();
    end
    repeat ($urandom_range(1, 4)) add_line();
    if (blk.size() > 1 && $urandom_range(99) < 15) begin
      cut = $urandom_range(1, blk.size() - 1);
      repeat (cut) void'(blk.pop_back());
    end
  endtask

  initial begin
    int first_len[4];
    int mode_bytes;
    int mode_blocks;
    int nset;
    hdr_ch.valid     = 1'b0;
    hdr_ch.data_byte = 8'h00;
    hdr_ch.block_end = 1'b0;
    res_ch.ready     = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_NAME_LOW;
    cfg_data         = 64'd0;
    rst              = 1'b1;
    src_pct          = 0;
    dst_pct          = 0;
    sent_bytes       = 0;
    sent_blocks      = 0;
    name_sets        = 0;
    cur_lo           = 64'd0;
    cur_hi           = 64'd0;
    cur_len          = 5'd1;
    first_len        = '{1, 16, 0, 31};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: one header with the default name, then "Host"
    blk.push_back(8'hFF);
    send_queue(1'b1);
    settle();
    load_name(HOST_LO, 64'd0, 64'd4);
    add_text("x\nHOST=v\n");
    send_queue(1'b1);
    blk.push_back(8'h78);
    blk.push_back(8'h00);
    send_queue(1'b1);
    // name length cut below the matched part in the middle of a line
    add_text("x\nHos");
    send_queue(1'b0);
    settle();
    load_name(HOST_LO, 64'd0, 64'd2);
    add_text(":q\n");
    send_queue(1'b1);

    // random blocks under each idle pattern
    for (int m = 0; m < 4; m++) begin
      settle();
      case (m)
        0: begin src_pct = 0;  dst_pct = 0;  end
        1: begin src_pct = 50; dst_pct = 0;  end
        2: begin src_pct = 0;  dst_pct = 50; end
        default: begin src_pct = 28; dst_pct = 28; end
      endcase
      mode_bytes  = 0;
      mode_blocks = 0;
      nset        = 0;
      while (mode_bytes < 412 || mode_blocks < 14) begin
        if (mode_blocks % 4 == 0) begin
          settle();
          pick_name((nset == 0) ? first_len[m] : -1, (nset == 0) && (m == 1));
          nset++;
        end
        build_block();
        mode_bytes += blk.size();
        send_queue(1'b1);
        mode_blocks++;
      end
    end

    settle();
    $display("run covered %0d header blocks, %0d bytes, %0d located values, %0d name settings",
             sent_blocks, sent_bytes, found_cnt, name_sets);
    $display("idle patterns none, sender, receiver and both");
    if (err_cnt == 0) begin
      $display("header_field_value_locator_unit: match");
    end else begin
      $display("header_field_value_locator_unit: mismatch");
    end
    $finish;
  end

endmodule
